FILE: design/lmtc_pkg.sv
// lmtc_pkg: widths, register indexes and pipeline types of the lightmap texel combine
// no dependencies; used by lmtc_div2 and lightmap_texel_combine
package lmtc_pkg;

	localparam int CH_W      = 8;   // byte sample and output channel
	localparam int SCALE_W   = 16;  // unsigned q4.12 scale
	localparam int FRAC_BITS = 12;
	localparam int PROD_W    = CH_W + SCALE_W;   // 24
	localparam int ACC_W     = PROD_W + 2;       // up to four maps
	localparam int LIN_W     = ACC_W - FRAC_BITS; // integer channel, 14 bits
	localparam int NUM_W     = LIN_W + CH_W;     // channel times 255
	localparam int NCH       = 3;                // red, green, blue
	localparam int CFG_W     = NCH * SCALE_W;    // widest register
	localparam int CFG_IDX_W = 3;
	localparam int MAPS_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MAPS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_BRIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MAP0  = 3'd2;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 16'h1000;
	localparam logic [CH_W-1:0]    CH_MAX    = 8'hFF;

	typedef logic [NCH-1:0][NUM_W-1:0] rem_vec_t;
	typedef logic [NCH-1:0][CH_W-1:0]  byte_vec_t;

	// everything that rides alongside the divider lanes
	typedef struct packed {
		logic [LIN_W-1:0] dvs;     // brightest channel
		logic             rescale; // brightest channel above 255
		byte_vec_t        lo;      // channels when no rescale is needed
		logic [CH_W-1:0]  alpha;   // brightest channel when no rescale
	} side_t;

endpackage

FILE: design/lmtc_div2.sv
// lmtc_div2: two restoring division steps on the three colour lanes
// depends on lmtc_pkg
module lmtc_div2 import lmtc_pkg::*; #(
	parameter int HI_BIT = 7
) (
	input  rem_vec_t         rem_i,
	input  byte_vec_t        quo_i,
	input  logic [LIN_W-1:0] dvs,
	output rem_vec_t         rem_o,
	output byte_vec_t        quo_o
);

	always_comb begin
		logic [NUM_W-1:0] r;
		logic [NUM_W-1:0] t_hi;
		logic [NUM_W-1:0] t_lo;
		logic [CH_W-1:0]  q;
		t_hi = NUM_W'(dvs) << HI_BIT;
		t_lo = NUM_W'(dvs) << (HI_BIT - 1);
		for (int c = 0; c < NCH; c++) begin
			r = rem_i[c];
			q = quo_i[c];
			if (r >= t_hi) begin
				r = r - t_hi;
				q[HI_BIT] = 1'b1;
			end
			if (r >= t_lo) begin
				r = r - t_lo;
				q[HI_BIT-1] = 1'b1;
			end
			rem_o[c] = r;
			quo_o[c] = q;
		end
	end

endmodule

FILE: design/lightmap_texel_combine.sv
// lightmap_texel_combine: blends up to four light style maps into one rgba8 texel
// depends on lmtc_pkg and lmtc_div2
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, red0..blue3          | into block
//  output  | out_valid, out_stall, out_red..out_alpha | out of block
//  config  | cfg_wr_en, cfg_index, cfg_data           | into block
//
// one item per clock while the output is not stalled, seven stages
// stages: scale multiply, map sum and max, times 255, then four stages of
// two restoring divide steps each for the rescale by the brightest channel
// every stage holds its item while the next one is full and stalled, so empty
// stages fill up behind a stalled output; in_stall is high only when all are full
// reset empties the pipeline and loads active_maps 1, full_bright 0, unit scales
module lightmap_texel_combine import lmtc_pkg::*; #(
	parameter int MAX_MAPS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CH_W-1:0]      red0,
	input  logic [CH_W-1:0]      green0,
	input  logic [CH_W-1:0]      blue0,
	input  logic [CH_W-1:0]      red1,
	input  logic [CH_W-1:0]      green1,
	input  logic [CH_W-1:0]      blue1,
	input  logic [CH_W-1:0]      red2,
	input  logic [CH_W-1:0]      green2,
	input  logic [CH_W-1:0]      blue2,
	input  logic [CH_W-1:0]      red3,
	input  logic [CH_W-1:0]      green3,
	input  logic [CH_W-1:0]      blue3,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CH_W-1:0]      out_red,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_blue,
	output logic [CH_W-1:0]      out_alpha
);

	// configuration registers
	logic [MAPS_W-1:0]  active_maps_q;
	logic               full_bright_q;
	logic [CFG_W-1:0]   scale_q [MAX_MAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_maps_q <= MAPS_W'(1);
			full_bright_q <= 1'b0;
			for (int m = 0; m < MAX_MAPS; m++) begin
				scale_q[m] <= {NCH{SCALE_ONE}};
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_ACTIVE_MAPS) begin
				active_maps_q <= cfg_data[MAPS_W-1:0];
			end
			if (cfg_index == REG_FULL_BRIGHT) begin
				full_bright_q <= cfg_data[0];
			end
			for (int m = 0; m < MAX_MAPS; m++) begin
				if (cfg_index == REG_SCALE_MAP0 + CFG_IDX_W'(m)) begin
					scale_q[m] <= cfg_data;
				end
			end
		end
	end

	// active count, saturated to the maps that exist
	logic [MAPS_W-1:0] maps_eff;
	assign maps_eff = (active_maps_q > MAPS_W'(MAX_MAPS)) ? MAPS_W'(MAX_MAPS) : active_maps_q;

	// samples by map and channel (red, green, blue)
	logic [CH_W-1:0] smp [4][NCH];
	always_comb begin
		smp[0][0] = red0; smp[0][1] = green0; smp[0][2] = blue0;
		smp[1][0] = red1; smp[1][1] = green1; smp[1][2] = blue1;
		smp[2][0] = red2; smp[2][1] = green2; smp[2][2] = blue2;
		smp[3][0] = red3; smp[3][1] = green3; smp[3][2] = blue3;
	end

	// stage valids and hand-over conditions
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	assign rdy7 = !valid_s7 || !out_stall;
	assign rdy6 = !valid_s6 || rdy7;
	assign rdy5 = !valid_s5 || rdy6;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
			if (rdy7) valid_s7 <= valid_s6;
		end
	end

	// stage 1: sample times scale, unused maps give zero
	logic [PROD_W-1:0] prod_s1 [MAX_MAPS][NCH];
	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			for (int m = 0; m < MAX_MAPS; m++) begin
				for (int c = 0; c < NCH; c++) begin
					if (MAPS_W'(m) < maps_eff) begin
						prod_s1[m][c] <= PROD_W'(smp[m][c]) *
							PROD_W'(scale_q[m][c*SCALE_W +: SCALE_W]);
					end else begin
						prod_s1[m][c] <= '0;
					end
				end
			end
		end
	end

	// stage 2: sum over maps, drop the fraction, find the brightest channel
	logic [LIN_W-1:0] ch_nx [NCH];
	logic [LIN_W-1:0] mx_nx;
	always_comb begin
		logic [ACC_W-1:0] acc;
		for (int c = 0; c < NCH; c++) begin
			acc = '0;
			for (int m = 0; m < MAX_MAPS; m++) begin
				acc = acc + ACC_W'(prod_s1[m][c]);
			end
			ch_nx[c] = acc[ACC_W-1:FRAC_BITS];
		end
		mx_nx = (ch_nx[0] > ch_nx[1]) ? ch_nx[0] : ch_nx[1];
		if (ch_nx[2] > mx_nx) mx_nx = ch_nx[2];
	end

	logic [LIN_W-1:0] ch_s2 [NCH];
	side_t            side_s2;
	always_ff @(posedge clk) begin
		if (valid_s1 && rdy2) begin
			for (int c = 0; c < NCH; c++) begin
				ch_s2[c]      <= ch_nx[c];
				side_s2.lo[c] <= ch_nx[c][CH_W-1:0];
			end
			side_s2.dvs     <= mx_nx;
			side_s2.rescale <= (mx_nx > LIN_W'(CH_MAX));
			side_s2.alpha   <= mx_nx[CH_W-1:0];
		end
	end

	// stage 3: dividend is channel times 255
	rem_vec_t rem_s3;
	side_t    side_s3;
	always_ff @(posedge clk) begin
		if (valid_s2 && rdy3) begin
			for (int c = 0; c < NCH; c++) begin
				rem_s3[c] <= (NUM_W'(ch_s2[c]) << CH_W) - NUM_W'(ch_s2[c]);
			end
			side_s3 <= side_s2;
		end
	end

	// stages 4 to 7: quotient bits two at a time, msb first
	rem_vec_t  rem_d4, rem_d5, rem_d6, rem_d7;
	byte_vec_t quo_d4, quo_d5, quo_d6, quo_d7;
	rem_vec_t  rem_s4, rem_s5, rem_s6;
	byte_vec_t quo_s4, quo_s5, quo_s6;
	side_t     side_s4, side_s5, side_s6;

	lmtc_div2 #(.HI_BIT(7)) u_div_76 (
		.rem_i(rem_s3), .quo_i('0), .dvs(side_s3.dvs), .rem_o(rem_d4), .quo_o(quo_d4)
	);
	lmtc_div2 #(.HI_BIT(5)) u_div_54 (
		.rem_i(rem_s4), .quo_i(quo_s4), .dvs(side_s4.dvs), .rem_o(rem_d5), .quo_o(quo_d5)
	);
	lmtc_div2 #(.HI_BIT(3)) u_div_32 (
		.rem_i(rem_s5), .quo_i(quo_s5), .dvs(side_s5.dvs), .rem_o(rem_d6), .quo_o(quo_d6)
	);
	lmtc_div2 #(.HI_BIT(1)) u_div_10 (
		.rem_i(rem_s6), .quo_i(quo_s6), .dvs(side_s6.dvs), .rem_o(rem_d7), .quo_o(quo_d7)
	);

	always_ff @(posedge clk) begin
		if (valid_s3 && rdy4) begin
			rem_s4  <= rem_d4;
			quo_s4  <= quo_d4;
			side_s4 <= side_s3;
		end
		if (valid_s4 && rdy5) begin
			rem_s5  <= rem_d5;
			quo_s5  <= quo_d5;
			side_s5 <= side_s4;
		end
		if (valid_s5 && rdy6) begin
			rem_s6  <= rem_d6;
			quo_s6  <= quo_d6;
			side_s6 <= side_s5;
		end
	end

	// stage 7: pick rescaled or plain channels, full bright overrides all
	byte_vec_t       rgb_s7;
	logic [CH_W-1:0] alpha_s7;
	always_ff @(posedge clk) begin
		if (valid_s6 && rdy7) begin
			for (int c = 0; c < NCH; c++) begin
				if (full_bright_q) begin
					rgb_s7[c] <= CH_MAX;
				end else if (side_s6.rescale) begin
					rgb_s7[c] <= quo_d7[c];
				end else begin
					rgb_s7[c] <= side_s6.lo[c];
				end
			end
			alpha_s7 <= (full_bright_q || side_s6.rescale) ? CH_MAX : side_s6.alpha;
		end
	end

	// remainder of the last step is not needed
	logic unused_rem;
	assign unused_rem = ^rem_d7;

	assign out_valid = valid_s7;
	assign out_red   = rgb_s7[0];
	assign out_green = rgb_s7[1];
	assign out_blue  = rgb_s7[2];
	assign out_alpha = alpha_s7;

endmodule
